>>> src/emfd_pkg.sv
// Shared constants, types and field helpers of the energy meter frame decoder.
// Depends on nothing; every other file refers to it by scoped names.
package emfd_pkg;

    localparam int FRAME_BYTES = 24;
    localparam int STORE_DEPTH = FRAME_BYTES - 2;
    localparam int POS_W       = 5;
    localparam int FRAC_BITS   = 8;
    localparam int VAL_W       = 24;
    localparam int DIVIDEND_W  = VAL_W + FRAC_BITS;
    localparam int RATIO_W     = 32;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);
    localparam int NUM_RATIOS  = 3;

    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'h5A;
    localparam logic [7:0] FLAG_VOLT  = 8'h40;
    localparam logic [7:0] FLAG_CURR  = 8'h20;
    localparam logic [7:0] FLAG_POWR  = 8'h10;

    // Byte positions within the frame
    localparam int POS_VOLT_COEF = 2;
    localparam int POS_VOLT_PER  = 5;
    localparam int POS_CURR_COEF = 8;
    localparam int POS_CURR_PER  = 11;
    localparam int POS_POWR_COEF = 14;
    localparam int POS_POWR_PER  = 17;
    localparam int POS_FLAGS     = 20;
    localparam int POS_PULSE_HI  = 21;
    localparam int POS_PULSE_LO  = 22;

    localparam logic [1:0] IDX_VOLT = 2'd0;
    localparam logic [1:0] IDX_CURR = 2'd1;
    localparam logic [1:0] IDX_POWR = 2'd2;

    // Frame bytes 2..23; frame byte k sits at element k-2
    typedef logic [STORE_DEPTH-1:0][7:0] frame_t;

    typedef struct packed {
        logic frame_rdy;
        logic sum_ok;
    } frm_stat_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [VAL_W-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_stat_t;

    // Big-endian 24-bit value starting at frame byte pos
    function automatic logic [VAL_W-1:0] get24(frame_t f, int unsigned pos);
        return {f[pos - 2], f[pos - 1], f[pos]};
    endfunction

endpackage

>>> src/emfd_framer.sv
// Header hunt, byte shift line and running checksum of the frame decoder.
// Depends on emfd_pkg.
module emfd_framer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_take,
    input  logic [7:0]         in_byte,
    input  logic               ack,
    output emfd_pkg::frm_stat_t stat,
    output emfd_pkg::frame_t    frame
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SEEN,
        PH_COLLECT
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [emfd_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [7:0]                    sum_reg, sum_next;
    logic                          rdy_reg, rdy_next;
    logic                          ok_reg, ok_next;
    emfd_pkg::frame_t              store_reg, store_next;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        rdy_next   = rdy_reg;
        ok_next    = ok_reg;
        store_next = store_reg;
        if (ack) begin
            rdy_next = 1'b0;
        end
        if (in_take) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    phase_next = (in_byte == emfd_pkg::HDR_FIRST) ? PH_SEEN : PH_HUNT;
                end
                PH_SEEN: begin
                    if (in_byte == emfd_pkg::HDR_SECOND) begin
                        phase_next = PH_COLLECT;
                        pos_next   = emfd_pkg::POS_W'(2);
                        sum_next   = 8'd0;
                    end else if (in_byte == emfd_pkg::HDR_FIRST) begin
                        phase_next = PH_SEEN;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_COLLECT: begin
                    // shift the byte in; oldest ends at element 0
                    store_next = {in_byte, store_reg[emfd_pkg::STORE_DEPTH-1:1]};
                    if (pos_reg == emfd_pkg::POS_W'(emfd_pkg::FRAME_BYTES - 1)) begin
                        ok_next    = (sum_reg == in_byte);
                        rdy_next   = 1'b1;
                        phase_next = PH_HUNT;
                        pos_next   = '0;
                        sum_next   = 8'd0;
                    end else begin
                        sum_next = sum_reg + in_byte;
                        pos_next = pos_reg + emfd_pkg::POS_W'(1);
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        store_reg <= store_next;
        ok_reg    <= ok_next;
        pos_reg   <= pos_next;
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            sum_reg   <= 8'd0;
            rdy_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            rdy_reg   <= rdy_next;
        end
    end

    assign stat.frame_rdy = rdy_reg;
    assign stat.sum_ok    = ok_reg;
    assign frame          = store_reg;

    a_rdy_after_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        rdy_reg |-> (phase_reg == PH_HUNT))
        else $error("framer left hunting while a frame awaits decoding");

endmodule

>>> src/emfd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on emfd_pkg.
module emfd_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  emfd_pkg::div_req_t  req,
    output emfd_pkg::div_stat_t stat
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [emfd_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [emfd_pkg::VAL_W-1:0]         rem_reg, rem_next;
    logic [emfd_pkg::VAL_W-1:0]         dsr_reg, dsr_next;
    logic [emfd_pkg::DIVIDEND_W-1:0]    quo_reg, quo_next;
    logic [emfd_pkg::VAL_W:0]           trial;
    logic [emfd_pkg::VAL_W:0]           diff;
    logic                               take;

    assign trial = {rem_reg, quo_reg[emfd_pkg::DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign take  = ~diff[emfd_pkg::VAL_W];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dsr_next  = req.divisor;
            quo_next  = req.dividend;
        end else if (busy_reg) begin
            rem_next = take ? diff[emfd_pkg::VAL_W-1:0] : trial[emfd_pkg::VAL_W-1:0];
            quo_next = {quo_reg[emfd_pkg::DIVIDEND_W-2:0], take};
            cnt_next = cnt_reg + emfd_pkg::DIV_CNT_W'(1);
            if (cnt_reg == emfd_pkg::DIV_CNT_W'(emfd_pkg::DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

endmodule

>>> src/energy_meter_frame_decoder.sv
// Energy meter frame decoder, top level. Takes one received serial byte per
// request, hunts for the 0x55 0x5A header (a run of 0x55 stays matched), shifts
// the remaining 22 bytes of the 24-byte frame into a byte line while summing
// bytes 2..22 modulo 256, and checks the sum against byte 23. After the last byte
// of a frame it gives exactly one result. A bad checksum gives checksum_ok low
// and every other field zero. For a good frame the voltage, current and power
// coefficients are each divided by their period readings into unsigned 24.8
// fixed point, truncated; a ratio is zero when its flag (0x40 voltage, 0x20
// current, 0x10 power in byte 20) is clear or its period is zero. Bytes that
// do not end a frame are taken back to back. The frame-ending byte starts the
// decode, which runs the three divisions one after another on a single
// bit-serial divider; each ratio steps through picking its operands, loading
// the divider, forming the quotient bits and collecting the quotient. Input is
// held off while the frame is noticed, these divisions run and the result is
// loaded, and longer only while the previous result still waits to be taken.
// Bytes keep being taken while a finished result waits in the output register;
// only a second completed frame waits for it to be taken.
// Depends on emfd_pkg, emfd_framer and emfd_div.
module energy_meter_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_voltage_ratio,
    output logic [31:0] m_current_ratio,
    output logic [31:0] m_power_ratio,
    output logic [15:0] m_pulse_count,
    output logic [7:0]  m_adjust_flags,
    output logic        m_checksum_ok
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PICK,
        ST_WAIT,
        ST_LOAD
    } state_t;

    emfd_pkg::frm_stat_t fstat;
    emfd_pkg::frame_t    frame;
    emfd_pkg::div_req_t  dreq;
    emfd_pkg::div_stat_t dstat;

    state_t                        state_reg, state_next;
    logic [1:0]                    idx_reg, idx_next;
    logic                          start_reg, start_next;
    logic [emfd_pkg::RATIO_W-1:0]  ratio_reg [emfd_pkg::NUM_RATIOS];
    logic [emfd_pkg::RATIO_W-1:0]  ratio_next [emfd_pkg::NUM_RATIOS];
    logic                          m_valid_reg, m_valid_next;
    logic [31:0]                   m_volt_reg, m_volt_next;
    logic [31:0]                   m_curr_reg, m_curr_next;
    logic [31:0]                   m_powr_reg, m_powr_next;
    logic [15:0]                   m_pulse_reg, m_pulse_next;
    logic [7:0]                    m_flags_reg, m_flags_next;
    logic                          m_ok_reg, m_ok_next;

    logic [emfd_pkg::VAL_W-1:0]    coef;
    logic [emfd_pkg::VAL_W-1:0]    period;
    logic                          flag_on;
    logic                          skip;
    logic                          out_free;
    logic                          ack;
    logic                          s_take;
    logic [7:0]                    flags_byte;

    // Hold off the byte stream while a completed frame is still being decoded
    assign s_ready = ~fstat.frame_rdy;
    assign s_take  = s_valid & s_ready;

    emfd_framer u_framer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (s_take),
        .in_byte (s_rx_byte),
        .ack     (ack),
        .stat    (fstat),
        .frame   (frame)
    );

    emfd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .stat    (dstat)
    );

    assign flags_byte = frame[emfd_pkg::POS_FLAGS - 2];

    // Select the coefficient, period and flag of the ratio in work
    always_comb begin
        unique case (idx_reg)
            emfd_pkg::IDX_VOLT: begin
                coef    = emfd_pkg::get24(frame, emfd_pkg::POS_VOLT_COEF);
                period  = emfd_pkg::get24(frame, emfd_pkg::POS_VOLT_PER);
                flag_on = |(flags_byte & emfd_pkg::FLAG_VOLT);
            end
            emfd_pkg::IDX_CURR: begin
                coef    = emfd_pkg::get24(frame, emfd_pkg::POS_CURR_COEF);
                period  = emfd_pkg::get24(frame, emfd_pkg::POS_CURR_PER);
                flag_on = |(flags_byte & emfd_pkg::FLAG_CURR);
            end
            emfd_pkg::IDX_POWR: begin
                coef    = emfd_pkg::get24(frame, emfd_pkg::POS_POWR_COEF);
                period  = emfd_pkg::get24(frame, emfd_pkg::POS_POWR_PER);
                flag_on = |(flags_byte & emfd_pkg::FLAG_POWR);
            end
            default: begin
                coef    = '0;
                period  = '0;
                flag_on = 1'b0;
            end
        endcase
    end

    // A ratio is zero on a bad checksum, a clear flag or a zero period
    assign skip = ~fstat.sum_ok | ~flag_on | (period == '0);

    assign dreq.start    = start_reg;
    assign dreq.dividend = emfd_pkg::DIVIDEND_W'(coef) << emfd_pkg::FRAC_BITS;
    assign dreq.divisor  = period;

    assign out_free = ~m_valid_reg | m_ready;
    assign ack      = (state_reg == ST_LOAD) & out_free;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        start_next   = 1'b0;
        ratio_next   = ratio_reg;
        m_valid_next = m_valid_reg;
        m_volt_next  = m_volt_reg;
        m_curr_next  = m_curr_reg;
        m_powr_next  = m_powr_reg;
        m_pulse_next = m_pulse_reg;
        m_flags_next = m_flags_reg;
        m_ok_next    = m_ok_reg;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (fstat.frame_rdy) begin
                    idx_next   = emfd_pkg::IDX_VOLT;
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (skip) begin
                    ratio_next[idx_reg] = '0;
                    if (idx_reg == emfd_pkg::IDX_POWR) begin
                        state_next = ST_LOAD;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end else begin
                    start_next = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (dstat.done) begin
                    ratio_next[idx_reg] = emfd_pkg::RATIO_W'(dstat.quotient);
                    if (idx_reg == emfd_pkg::IDX_POWR) begin
                        state_next = ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_PICK;
                    end
                end
            end
            ST_LOAD: begin
                // hold until the output register is free, then release the framer
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_volt_next  = ratio_reg[emfd_pkg::IDX_VOLT];
                    m_curr_next  = ratio_reg[emfd_pkg::IDX_CURR];
                    m_powr_next  = ratio_reg[emfd_pkg::IDX_POWR];
                    m_ok_next    = fstat.sum_ok;
                    if (fstat.sum_ok) begin
                        m_pulse_next = {frame[emfd_pkg::POS_PULSE_HI - 2],
                                        frame[emfd_pkg::POS_PULSE_LO - 2]};
                        m_flags_next = flags_byte;
                    end else begin
                        m_pulse_next = 16'd0;
                        m_flags_next = 8'd0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        ratio_reg   <= ratio_next;
        m_volt_reg  <= m_volt_next;
        m_curr_reg  <= m_curr_next;
        m_powr_reg  <= m_powr_next;
        m_pulse_reg <= m_pulse_next;
        m_flags_reg <= m_flags_next;
        m_ok_reg    <= m_ok_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_voltage_ratio = m_volt_reg;
    assign m_current_ratio = m_curr_reg;
    assign m_power_ratio   = m_powr_reg;
    assign m_pulse_count   = m_pulse_reg;
    assign m_adjust_flags  = m_flags_reg;
    assign m_checksum_ok   = m_ok_reg;

    a_no_bytes_in_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("byte request accepted while a frame is being decoded");

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> !dstat.busy)
        else $error("divider started while still busy");

    a_result_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_LOAD))
        else $error("result appeared outside the load step");

    a_bad_sum_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_checksum_ok) |-> (m_voltage_ratio == '0 && m_current_ratio == '0
            && m_power_ratio == '0 && m_pulse_count == '0 && m_adjust_flags == '0))
        else $error("bad checksum result carries non-zero fields");

endmodule

>>> dv/tb_energy_meter_frame_decoder.sv
// Self-checking bench for the energy meter frame decoder: streams serial bytes, predicts
// each decoded frame and compares every result field against the block's output.
// Depends on emfd_pkg and energy_meter_frame_decoder.
module tb_energy_meter_frame_decoder;

    localparam int CLK_PERIOD       = 12;
    localparam int RUN_LIMIT_CYCLES = 300000;
    localparam int SETTLE_CYCLES    = 300;
    localparam int MAX_REPORTS      = 10;
    localparam int HOLD_OFF_CYCLES  = 700;
    localparam int LAST_BYTE        = emfd_pkg::FRAME_BYTES - 1;

    // Framer phases of the predictor
    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SEEN_FIRST,
        PH_COLLECT
    } sync_phase_t;

    // One decoded frame, laid out in port order so it compares as a whole
    typedef struct packed {
        logic [31:0] voltage_ratio;
        logic [31:0] current_ratio;
        logic [31:0] power_ratio;
        logic [15:0] pulse_count;
        logic [7:0]  adjust_flags;
        logic        checksum_ok;
    } meter_reading_t;

    logic        aclk;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte       = 8'h00;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [31:0] m_voltage_ratio;
    logic [31:0] m_current_ratio;
    logic [31:0] m_power_ratio;
    logic [15:0] m_pulse_count;
    logic [7:0]  m_adjust_flags;
    logic        m_checksum_ok;

    // Predictor state: framer phase, next frame byte, running sum and frame copy
    sync_phase_t    pred_phase = PH_HUNT;
    int unsigned    pred_pos   = 0;
    logic [7:0]     pred_sum   = 8'h00;
    logic [7:0]     pred_frame [emfd_pkg::FRAME_BYTES];
    meter_reading_t pending_readings [$];

    // Frame under construction on the sending side
    logic [7:0] tx_frame [emfd_pkg::FRAME_BYTES];

    // Idling controls, shared between the test tasks, the byte sender and the output stall process
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;

    int bytes_accepted   = 0;
    int frame_bytes_sent = 0;
    int frames_sent      = 0;
    int corrupt_frames   = 0;
    int readings_checked = 0;
    int failures         = 0;

    energy_meter_frame_decoder uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_voltage_ratio (m_voltage_ratio),
        .m_current_ratio (m_current_ratio),
        .m_power_ratio   (m_power_ratio),
        .m_pulse_count   (m_pulse_count),
        .m_adjust_flags  (m_adjust_flags),
        .m_checksum_ok   (m_checksum_ok)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Unsigned 24.8 quotient, truncated; zero when the flag is clear or the period is zero
    function automatic logic [31:0] fixed_ratio(input logic [23:0] coef,
                                                input logic [23:0] period,
                                                input logic enabled);
        logic [31:0] dividend;
        dividend = 32'(coef) << emfd_pkg::FRAC_BITS;
        if (!enabled || period == '0) return '0;
        return dividend / {8'h00, period};
    endfunction

    // Big-endian 24-bit reading starting at frame byte pos
    function automatic logic [23:0] frame_word(input int unsigned pos);
        return {pred_frame[pos], pred_frame[pos + 1], pred_frame[pos + 2]};
    endfunction

    // Advance the predicted framer by one accepted byte; queue a reading at frame end
    function automatic void predict_byte(input logic [7:0] b);
        meter_reading_t r;
        logic [7:0]     adj;
        case (pred_phase)
            PH_COLLECT: begin
                pred_frame[pred_pos] = b;
                if (pred_pos < LAST_BYTE) begin
                    pred_sum += b;
                    pred_pos++;
                end else begin
                    r   = '0;
                    adj = pred_frame[emfd_pkg::POS_FLAGS];
                    if (pred_sum == b) begin
                        r.voltage_ratio = fixed_ratio(frame_word(emfd_pkg::POS_VOLT_COEF),
                                                      frame_word(emfd_pkg::POS_VOLT_PER),
                                                      (adj & emfd_pkg::FLAG_VOLT) != '0);
                        r.current_ratio = fixed_ratio(frame_word(emfd_pkg::POS_CURR_COEF),
                                                      frame_word(emfd_pkg::POS_CURR_PER),
                                                      (adj & emfd_pkg::FLAG_CURR) != '0);
                        r.power_ratio   = fixed_ratio(frame_word(emfd_pkg::POS_POWR_COEF),
                                                      frame_word(emfd_pkg::POS_POWR_PER),
                                                      (adj & emfd_pkg::FLAG_POWR) != '0);
                        r.pulse_count   = {pred_frame[emfd_pkg::POS_PULSE_HI],
                                           pred_frame[emfd_pkg::POS_PULSE_LO]};
                        r.adjust_flags  = adj;
                        r.checksum_ok   = 1'b1;
                    end
                    pending_readings.push_back(r);
                    pred_phase = PH_HUNT;
                    pred_pos   = 0;
                    pred_sum   = '0;
                end
            end
            PH_SEEN_FIRST: begin
                // A repeated first header byte keeps the match alive
                if (b == emfd_pkg::HDR_SECOND) begin
                    pred_phase = PH_COLLECT;
                    pred_pos   = 2;
                    pred_sum   = '0;
                end else if (b != emfd_pkg::HDR_FIRST) begin
                    pred_phase = PH_HUNT;
                end
            end
            default: begin
                pred_phase = (b == emfd_pkg::HDR_FIRST) ? PH_SEEN_FIRST : PH_HUNT;
                pred_pos   = 0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one byte after a random gap; hold it until the request is taken.
    // Valid is only lowered when a gap follows, so back-to-back bytes keep it high.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict_byte(b);
        bytes_accepted++;
    endtask

    // Drop valid and pause until every predicted reading has been checked.
    // The pause always waits on the clock before it checks, so valid is never lowered and raised in one step.
    task automatic drain_readings();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_readings.size() != 0);
    endtask

    task automatic load_frame(input logic [23:0] v_coef, input logic [23:0] v_per,
                              input logic [23:0] c_coef, input logic [23:0] c_per,
                              input logic [23:0] p_coef, input logic [23:0] p_per,
                              input logic [7:0] flags, input logic [15:0] pulses);
        {tx_frame[0], tx_frame[1]} = {emfd_pkg::HDR_FIRST, emfd_pkg::HDR_SECOND};
        {tx_frame[2], tx_frame[3], tx_frame[4]}    = v_coef;
        {tx_frame[5], tx_frame[6], tx_frame[7]}    = v_per;
        {tx_frame[8], tx_frame[9], tx_frame[10]}   = c_coef;
        {tx_frame[11], tx_frame[12], tx_frame[13]} = c_per;
        {tx_frame[14], tx_frame[15], tx_frame[16]} = p_coef;
        {tx_frame[17], tx_frame[18], tx_frame[19]} = p_per;
        tx_frame[emfd_pkg::POS_FLAGS] = flags;
        {tx_frame[emfd_pkg::POS_PULSE_HI], tx_frame[emfd_pkg::POS_PULSE_LO]} = pulses;
    endtask

    // Seal the loaded frame with its checksum (or a wrong one) and send all of it
    task automatic send_frame(input bit corrupt);
        logic [7:0] sum;
        sum = '0;
        for (int k = 2; k < LAST_BYTE; k++) sum += tx_frame[k];
        if (corrupt) begin
            sum += 8'($urandom_range(1, 255));
            corrupt_frames++;
        end
        tx_frame[LAST_BYTE] = sum;
        for (int k = 0; k < emfd_pkg::FRAME_BYTES; k++) send_byte(tx_frame[k]);
        frame_bytes_sent += emfd_pkg::FRAME_BYTES;
        frames_sent++;
    endtask

    // Biased 24-bit reading: zero, all ones, one and small values turn up often
    function automatic logic [23:0] random_reading_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 24'd1;
            3:       return 24'($urandom_range(1, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_random_frame();
        logic [7:0] flags;
        flags = 8'($urandom);
        if ($urandom_range(0, 2) != 0)
            flags |= emfd_pkg::FLAG_VOLT | emfd_pkg::FLAG_CURR | emfd_pkg::FLAG_POWR;
        // Lead in with extra first header bytes now and then
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_byte(emfd_pkg::HDR_FIRST);
        load_frame(random_reading_word(), random_reading_word(), random_reading_word(),
                   random_reading_word(), random_reading_word(), random_reading_word(),
                   flags, 16'($urandom));
        // Scatter header values through the payload; they must be taken as data
        for (int k = 2; k < LAST_BYTE; k++)
            if ($urandom_range(0, 19) == 0)
                tx_frame[k] = $urandom_range(0, 1) ? emfd_pkg::HDR_FIRST : emfd_pkg::HDR_SECOND;
        send_frame($urandom_range(0, 99) < 15);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Stall at random, or hold off entirely while a hold-off count is running
    always @(posedge aclk) begin
        if (hold_off_left > 0) begin
            m_ready <= 1'b0;
            hold_off_left--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each taken result with the oldest predicted reading
    always @(posedge aclk) begin
        meter_reading_t got;
        meter_reading_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_voltage_ratio, m_current_ratio, m_power_ratio,
                   m_pulse_count, m_adjust_flags, m_checksum_ok};
            readings_checked++;
            if (pending_readings.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result at %0t: V=%h I=%h P=%h pulses=%h flags=%h ok=%b",
                             $time, got.voltage_ratio, got.current_ratio, got.power_ratio,
                             got.pulse_count, got.adjust_flags, got.checksum_ok);
            end else begin
                want = pending_readings.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("reading %0d mismatch at %0t", readings_checked, $time);
                        $display("  expected V=%h I=%h P=%h pulses=%h flags=%h ok=%b",
                                 want.voltage_ratio, want.current_ratio, want.power_ratio,
                                 want.pulse_count, want.adjust_flags, want.checksum_ok);
                        $display("  actual   V=%h I=%h P=%h pulses=%h flags=%h ok=%b",
                                 got.voltage_ratio, got.current_ratio, got.power_ratio,
                                 got.pulse_count, got.adjust_flags, got.checksum_ok);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Largest and smallest quotients, all flags set, pulse counter at both ends
    task automatic test_ratio_extremes();
        load_frame(24'hFFFFFF, 24'h000001, 24'h000001, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   8'hFF, 16'hFFFF);
        send_frame(1'b0);
        load_frame(24'h000000, 24'h800000, 24'h000100, 24'h000003, 24'h7FFFFF, 24'h000002,
                   emfd_pkg::FLAG_VOLT | emfd_pkg::FLAG_CURR | emfd_pkg::FLAG_POWR, 16'h0000);
        send_frame(1'b0);
        drain_readings();
    endtask

    // Zero period with its flag set, and cleared flags with and without a period
    task automatic test_flag_and_zero_period();
        load_frame(24'h123456, 24'h000000, 24'h654321, 24'h000010, 24'hABCDEF, 24'h000000,
                   8'h8F | emfd_pkg::FLAG_VOLT, 16'h1234);
        send_frame(1'b0);
        load_frame(24'h00FFFF, 24'h000100, 24'hFEDCBA, 24'h000000, 24'h000042, 24'h000007,
                   emfd_pkg::FLAG_CURR | emfd_pkg::FLAG_POWR, 16'h8001);
        send_frame(1'b0);
        drain_readings();
    endtask

    // Wrong checksum: every field but the status must come back zero
    task automatic test_bad_checksum();
        load_frame(24'h111111, 24'h000003, 24'h222222, 24'h000005, 24'h333333, 24'h000007,
                   8'hFF, 16'hBEEF);
        send_frame(1'b1);
        drain_readings();
    endtask

    // Run of first header bytes before a frame, a broken header, a lone second header byte,
    // then a frame whose payload itself looks like a header
    task automatic test_header_resync();
        repeat (3) send_byte(emfd_pkg::HDR_FIRST);
        load_frame(24'h000200, 24'h000010, 24'h000001, 24'h000001, 24'h000000, 24'h000001,
                   8'h70, 16'h0102);
        send_frame(1'b0);
        send_byte(emfd_pkg::HDR_FIRST);
        send_byte(8'h12);
        send_byte(emfd_pkg::HDR_SECOND);
        load_frame(24'h555A55, 24'h5A5555, 24'h55555A, 24'h5A5A5A, 24'h000055, 24'h00005A,
                   8'h5A, 16'h555A);
        send_frame(1'b0);
        drain_readings();
    endtask

    // Hold the output off while three frames arrive back to back: the first reading
    // parks in the output register, the second frame's end is held, the input stalls
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = HOLD_OFF_CYCLES;
        repeat (3) send_random_frame();
        drain_readings();
    endtask

    // Mostly well-formed frames with random content, salted with noise and broken headers
    task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                     input int frame_byte_goal);
        int         start_bytes;
        int         start_frames;
        logic [7:0] stray;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_bytes    = frame_bytes_sent;
        start_frames   = frames_sent;
        while (frame_bytes_sent - start_bytes < frame_byte_goal ||
               frames_sent - start_frames < 7) begin
            case ($urandom_range(0, 19))
                0, 1: repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                2: begin
                    stray = 8'($urandom);
                    if (stray == emfd_pkg::HDR_SECOND) stray = ~stray;
                    send_byte(emfd_pkg::HDR_FIRST);
                    send_byte(stray);
                end
                3: send_byte(emfd_pkg::HDR_SECOND);
                default: send_random_frame();
            endcase
        end
        drain_readings();
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(0, 0, 168);
        run_traffic_phase(79, 0, 168);
        run_traffic_phase(0, 79, 168);
        run_traffic_phase(10, 10, 168);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ratio_extremes();
        test_flag_and_zero_period();
        test_bad_checksum();
        test_header_resync();
        test_output_backpressure();
        test_random_traffic();

        // Give a stray extra result time to show up
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_readings.size() != 0) begin
            $display("%0d predicted readings never arrived", pending_readings.size());
            failures += pending_readings.size();
        end

        $display("checked %0d readings from %0d bytes: %0d frames, %0d with a bad checksum",
                 readings_checked, bytes_accepted, frames_sent, corrupt_frames);
        $display("covered header resync, cleared flags, zero periods and a long output hold-off");
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d failures", failures);
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("timed out with %0d readings outstanding", pending_readings.size());
        $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
src/emfd_pkg.sv
src/emfd_framer.sv
src/emfd_div.sv
src/energy_meter_frame_decoder.sv
dv/tb_energy_meter_frame_decoder.sv
